// File: sv/ckcc_pkg.sv
package ckcc_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int BLK_W   = 64;
    localparam int SUM_W   = 32;
    localparam int TAG_W   = BLK_W + SUM_W;
    localparam int SLOT_W  = 10;
    localparam int OCC_W   = 11;

    localparam logic [2:0] OC_MISS     = 3'd0;
    localparam logic [2:0] OC_HIT      = 3'd1;
    localparam logic [2:0] OC_UPDATED  = 3'd2;
    localparam logic [2:0] OC_FILLED   = 3'd3;
    localparam logic [2:0] OC_REPLACED = 3'd4;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [BLK_W-1:0] block_number;
        logic [SUM_W-1:0] checksum;
    } req_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic [SLOT_W-1:0] slot_index;
        logic [BLK_W-1:0]  evicted_block;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

// File: sv/checksum_keyed_clock_cache_tags_core.sv
// Sequence: block 0 strobes done in the cycle after the transfer, with no search. Otherwise
// a linear tag search walks the filled entries; with no match a get ends in a miss and a put
// fills a free entry, or when none is free runs the CLOCK scan and a victim read to replace.
// Throughput: one request at a time; busy is high until the result strobe cycle (block 0 never raises busy).
// Reset: occupancy and clock hand cleared; tag memories need no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per request.
module checksum_keyed_clock_cache_tags_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ckcc_pkg::req_t   req,
    output logic             done,
    output ckcc_pkg::result_t result
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD      = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_CLK_RD  = 3'd3;
    localparam logic [2:0] S_CLK_CHK = 3'd4;
    localparam logic [2:0] S_EV_RD   = 3'd5;
    localparam logic [2:0] S_EV_WR   = 3'd6;

    localparam logic [ckcc_pkg::IDX_W-1:0] LAST_IDX = ckcc_pkg::IDX_W'(ckcc_pkg::ENTRIES - 1);
    localparam logic [ckcc_pkg::CNT_W-1:0] FULL_CNT = ckcc_pkg::CNT_W'(ckcc_pkg::ENTRIES);

    logic [2:0]                   state_reg, state_next;
    logic [ckcc_pkg::CNT_W-1:0]   occ_reg, occ_next;
    logic [ckcc_pkg::IDX_W-1:0]   hand_reg, hand_next;
    logic [ckcc_pkg::CNT_W-1:0]   ptr_reg, ptr_next;
    ckcc_pkg::req_t               req_reg, req_next;
    logic                         done_reg, done_next;
    ckcc_pkg::result_t            result_reg, result_next;

    logic                         tag_we;
    logic                         sc_we;
    logic                         sc_wdata;
    logic [ckcc_pkg::IDX_W-1:0]   wr_addr;
    logic [ckcc_pkg::TAG_W-1:0]   tag_rdata;
    logic [0:0]                   sc_rdata;
    logic [ckcc_pkg::IDX_W-1:0]   hand_inc;
    logic [ckcc_pkg::IDX_W-1:0]   ptr_idx;
    logic [ckcc_pkg::BLK_W-1:0]   tag_blk;
    logic [ckcc_pkg::SUM_W-1:0]   tag_sum;

    assign ptr_idx  = ptr_reg[ckcc_pkg::IDX_W-1:0];
    assign hand_inc = (hand_reg == LAST_IDX) ? '0 : hand_reg + 1'b1;
    assign tag_blk  = tag_rdata[ckcc_pkg::TAG_W-1:ckcc_pkg::SUM_W];
    assign tag_sum  = tag_rdata[ckcc_pkg::SUM_W-1:0];

    ckcc_ram #(
        .WIDTH (ckcc_pkg::TAG_W),
        .DEPTH (ckcc_pkg::ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (wr_addr),
        .wdata ({req_reg.block_number, req_reg.checksum}),
        .raddr (ptr_idx),
        .rdata (tag_rdata)
    );

    // every entry gets its bit set when filled, so the scan never reads an unwritten bit
    ckcc_ram #(
        .WIDTH (1),
        .DEPTH (ckcc_pkg::ENTRIES)
    ) u_sc_ram (
        .clk   (clk),
        .we    (sc_we),
        .waddr (wr_addr),
        .wdata (sc_wdata),
        .raddr (hand_reg),
        .rdata (sc_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        hand_next   = hand_reg;
        ptr_next    = ptr_reg;
        req_next    = req_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        tag_we      = 1'b0;
        sc_we       = 1'b0;
        sc_wdata    = 1'b1;
        wr_addr     = ptr_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    ptr_next = '0;
                    if (req.block_number == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{ckcc_pkg::OC_MISS, '0, '0, ckcc_pkg::to_occ(occ_reg)};
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (ptr_reg == occ_reg)
                begin
                    if (req_reg.req_type == ckcc_pkg::REQ_GET)
                    begin
                        done_next   = 1'b1;
                        result_next = '{ckcc_pkg::OC_MISS, '0, '0, ckcc_pkg::to_occ(occ_reg)};
                        state_next  = S_IDLE;
                    end
                    else if (occ_reg < FULL_CNT)
                    begin
                        wr_addr     = occ_reg[ckcc_pkg::IDX_W-1:0];
                        tag_we      = 1'b1;
                        sc_we       = 1'b1;
                        occ_next    = occ_reg + 1'b1;
                        done_next   = 1'b1;
                        result_next = '{ckcc_pkg::OC_FILLED,
                                        ckcc_pkg::to_slot(occ_reg[ckcc_pkg::IDX_W-1:0]),
                                        '0, ckcc_pkg::to_occ(occ_reg + 1'b1)};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CLK_RD;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (tag_blk == req_reg.block_number)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (req_reg.req_type == ckcc_pkg::REQ_PUT)
                    begin
                        tag_we      = 1'b1;
                        sc_we       = 1'b1;
                        result_next = '{ckcc_pkg::OC_UPDATED, ckcc_pkg::to_slot(ptr_idx),
                                        '0, ckcc_pkg::to_occ(occ_reg)};
                    end
                    else if (tag_sum == req_reg.checksum)
                    begin
                        sc_we       = 1'b1;
                        result_next = '{ckcc_pkg::OC_HIT, ckcc_pkg::to_slot(ptr_idx),
                                        '0, ckcc_pkg::to_occ(occ_reg)};
                    end
                    else
                    begin
                        result_next = '{ckcc_pkg::OC_MISS, '0, '0, ckcc_pkg::to_occ(occ_reg)};
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_CLK_RD:
            begin
                state_next = S_CLK_CHK;
            end
            S_CLK_CHK:
            begin
                hand_next = hand_inc;
                if (sc_rdata == 1'b0)
                begin
                    ptr_next   = ckcc_pkg::CNT_W'(hand_reg);
                    state_next = S_EV_RD;
                end
                else
                begin
                    wr_addr    = hand_reg;
                    sc_we      = 1'b1;
                    sc_wdata   = 1'b0;
                    state_next = S_CLK_RD;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_WR;
            end
            S_EV_WR:
            begin
                tag_we      = 1'b1;
                sc_we       = 1'b1;
                done_next   = 1'b1;
                result_next = '{ckcc_pkg::OC_REPLACED, ckcc_pkg::to_slot(ptr_idx),
                                tag_blk, ckcc_pkg::to_occ(occ_reg)};
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            hand_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            hand_reg  <= hand_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in progress");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy beyond entry count");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outcome == ckcc_pkg::OC_MISS) |->
            (result.slot_index == '0 && result.evicted_block == '0))
        else $error("miss carries a slot or evicted block");

    a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outcome == ckcc_pkg::OC_FILLED) |->
            (occ_reg == $past(occ_reg) + 1'b1))
        else $error("fill without occupancy increment");

    a_replace_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outcome == ckcc_pkg::OC_REPLACED) |-> (occ_reg == FULL_CNT))
        else $error("replacement while free entries remain");

endmodule

// File: sv/ckcc_ram.sv
module ckcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
